// ----- rtl/cvv_pkg.sv -----
// Package for the column value validator.
// Holds character constants, the recognizer phase type, register indexes
// and the structs passed between the block's modules. No dependencies.
package cvv_pkg;

   localparam int DEFAULT_MAX_VALUE_LENGTH = 65535;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_KIND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH  = 2'd1;

   localparam logic KIND_STRING = 1'b0;
   localparam logic KIND_NUMBER = 1'b1;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;

   typedef enum logic [6:0] {
      PH_START    = 7'b0000001,
      PH_INT      = 7'b0000010,
      PH_FRAC     = 7'b0000100,
      PH_EXP      = 7'b0001000,
      PH_EXP_SIGN = 7'b0010000,
      PH_EXP_NUM  = 7'b0100000,
      PH_REJECT   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       column_kind;
      logic [15:0] max_length;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic accepted;
   } verdict_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS);
   endfunction

   function automatic logic is_exp_mark(input logic [7:0] c);
      return (c == CHAR_LOW_E) || (c == CHAR_UP_E);
   endfunction

endpackage

// ----- rtl/cvv_req_if.sv -----
// Request channel of the column value validator: one character per transaction.
// Depends on nothing.
interface cvv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;
   logic       empty_value;

   modport source (output valid, output char_code, output last_char,
                   output empty_value, input ready);
   modport sink   (input valid, input char_code, input last_char,
                   input empty_value, output ready);
endinterface

// ----- rtl/cvv_rsp_if.sv -----
// Response channel of the column value validator: one verdict per value.
// Depends on nothing.
interface cvv_rsp_if;
   logic valid;
   logic ready;
   logic accepted;

   modport source (output valid, output accepted, input ready);
   modport sink   (input valid, input accepted, output ready);
endinterface

// ----- rtl/cvv_csr.sv -----
// Configuration registers: column kind and string length limit.
// Depends on cvv_pkg.
module cvv_csr
   import cvv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_COLUMN_KIND: cfg_in.column_kind = wr_data[0];
            CSR_MAX_LENGTH:  cfg_in.max_length  = wr_data[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/cvv_scan.sv -----
// Per-character scanner: length counter, number recognizer, verdict on last item.
// Depends on cvv_pkg.
module cvv_scan
   import cvv_pkg::*;
#(
   parameter int MAX_VALUE_LENGTH = DEFAULT_MAX_VALUE_LENGTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  char_code,
   input  logic        last_char,
   input  logic        empty_value,
   input  cfg_type     cfg,
   output verdict_type verdict
);

   localparam int CW  = $clog2(MAX_VALUE_LENGTH + 2);
   localparam int LW  = (CW > 16) ? CW : 16;
   localparam int SAT = MAX_VALUE_LENGTH + 1;

   phase_type         phase_ff, phase_in, phase_nxt;
   logic              seen_ff, seen_in, seen_nxt;
   logic [CW-1:0]     count_ff, count_in, count_nxt;
   logic              digit, len_ok, num_ok;

   assign digit = is_digit(char_code);

   always_comb begin
      phase_nxt = phase_ff;
      seen_nxt  = seen_ff;
      count_nxt = count_ff;
      if (!empty_value) begin
         if (count_ff < CW'(SAT)) begin
            count_nxt = count_ff + CW'(1);
         end
         unique case (phase_ff)
            PH_START: begin
               if (is_sign(char_code)) phase_nxt = PH_INT;
               else if (digit) begin
                  phase_nxt = PH_INT;
                  seen_nxt  = 1'b1;
               end else if (char_code == CHAR_DOT) phase_nxt = PH_FRAC;
               else phase_nxt = PH_REJECT;
            end
            PH_INT: begin
               if (digit) begin
                  phase_nxt = PH_INT;
                  seen_nxt  = 1'b1;
               end else if (char_code == CHAR_DOT) phase_nxt = PH_FRAC;
               else if (is_exp_mark(char_code)) phase_nxt = PH_EXP;
               else phase_nxt = PH_REJECT;
            end
            PH_FRAC: begin
               if (digit) begin
                  phase_nxt = PH_FRAC;
                  seen_nxt  = 1'b1;
               end else if (is_exp_mark(char_code)) phase_nxt = PH_EXP;
               else phase_nxt = PH_REJECT;
            end
            PH_EXP: begin
               if (digit) phase_nxt = PH_EXP_NUM;
               else if (is_sign(char_code)) phase_nxt = PH_EXP_SIGN;
               else phase_nxt = PH_REJECT;
            end
            PH_EXP_SIGN, PH_EXP_NUM: begin
               phase_nxt = digit ? PH_EXP_NUM : PH_REJECT;
            end
            default: phase_nxt = PH_REJECT;
         endcase
      end
   end

   // saturated count is above MAX_VALUE_LENGTH, so it always fails here
   assign len_ok = (count_nxt <= CW'(MAX_VALUE_LENGTH)) &&
                   (LW'(count_nxt) <= LW'(cfg.max_length));
   assign num_ok = seen_nxt && ((phase_nxt == PH_INT) || (phase_nxt == PH_FRAC) ||
                                (phase_nxt == PH_EXP_NUM));

   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      count_in = count_ff;
      if (take) begin
         if (last_char) begin
            phase_in = PH_START;
            seen_in  = 1'b0;
            count_in = '0;
         end else begin
            phase_in = phase_nxt;
            seen_in  = seen_nxt;
            count_in = count_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         seen_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   assign verdict.push     = take && last_char;
   assign verdict.accepted = (cfg.column_kind == KIND_NUMBER) ? num_ok : len_ok;

endmodule

// ----- rtl/cvv_out_reg.sv -----
// Result register holding one verdict until the receiver takes it.
// Depends on cvv_pkg.
module cvv_out_reg
   import cvv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  verdict_type verdict,
   output logic        can_take,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_accepted
);

   logic valid_ff, valid_in;
   logic accepted_ff, accepted_in;

   // room when empty or when the held verdict leaves this cycle
   assign can_take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in    = valid_ff;
      accepted_in = accepted_ff;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (verdict.push) begin
         valid_in    = 1'b1;
         accepted_in = verdict.accepted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      accepted_ff <= accepted_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_accepted = accepted_ff;

endmodule

// ----- rtl/column_value_validator_top.sv -----
// Column value validator, top level.
// Depends on cvv_pkg, cvv_req_if, cvv_rsp_if, cvv_csr, cvv_scan, cvv_out_reg.
//
// Usage:
//   req_bus carries one character per transaction; last_char marks the end of
//   a value, and an empty value is a single transaction with empty_value and
//   last_char set. rsp_bus returns one verdict (accepted) per value.
//   csr_wr_en/csr_index/csr_wr_data write column_kind (index 0) and
//   max_length (index 1); write them only while no value is in flight.
// Timing:
//   One character per cycle while req_bus.ready is high. The verdict of a value
//   appears on rsp_bus in the cycle after its last character is taken, from a
//   single result register. The scanner state updates in the accepting cycle,
//   so there is no bubble between values.
// Stall:
//   While a verdict waits and rsp_bus.ready is low, req_bus.ready drops; it
//   rises again in the cycle the receiver takes the verdict.
// Reset:
//   Synchronous, active high; clears the registers to string mode with
//   limit zero, empties the result register and restarts the scanner.
module column_value_validator_top
   import cvv_pkg::*;
#(
   parameter int MAX_VALUE_LENGTH = DEFAULT_MAX_VALUE_LENGTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   cvv_req_if.sink                req_bus,
   cvv_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   cfg_type     cfg;
   verdict_type verdict;
   logic        can_take;
   logic        take;

   assign req_bus.ready = can_take;
   assign take          = req_bus.valid && can_take;

   cvv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   cvv_scan #(
      .MAX_VALUE_LENGTH (MAX_VALUE_LENGTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .char_code   (req_bus.char_code),
      .last_char   (req_bus.last_char),
      .empty_value (req_bus.empty_value),
      .cfg         (cfg),
      .verdict     (verdict)
   );

   cvv_out_reg u_out (
      .clock        (clock),
      .reset        (reset),
      .verdict      (verdict),
      .can_take     (can_take),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_accepted (rsp_bus.accepted)
   );

endmodule

// ----- bench/tb_column_value_validator_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for column_value_validator_top: streams column values one
// character per transaction and predicts each verdict in string and number mode.
// Depends on cvv_pkg, cvv_req_if, cvv_rsp_if and the validator RTL.
module tb_column_value_validator_top;
   import cvv_pkg::*;

   localparam int VALUE_LIMIT    = DEFAULT_MAX_VALUE_LENGTH;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int ITEMS_PER_STEP = 220;

   // indexes past the register list; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_value;
   } char_item_type;

   typedef logic [7:0] byte_queue_type[$];

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COLUMN_KIND;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   cvv_req_if req_bus();
   cvv_rsp_if rsp_bus();

   column_value_validator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state and register copies
   logic        kind_reg     = KIND_STRING;
   logic [15:0] length_limit = '0;
   phase_type   number_phase = PH_START;
   logic        digit_seen   = 1'b0;
   int          value_length = 0;

   char_item_type pending_chars[$];
   logic          expected_verdicts[$];

   int  sender_idle_pct    = 0;
   int  receiver_stall_pct = 0;
   bit  req_taken          = 1'b0;
   int  stall_cycles       = 0;
   int  mismatch_count     = 0;
   int  chars_sent         = 0;
   int  verdicts_seen      = 0;
   int  verdicts_accepted  = 0;

   char_item_type next_char;
   char_item_type seen_char;
   logic          predicted;
   logic          has_verdict;

   function automatic logic predict_verdict(input char_item_type it, output logic verdict);
      logic digit;
      logic sign;
      logic exp_mark;
      logic dot;
      digit    = (it.char_code >= CHAR_ZERO) && (it.char_code <= CHAR_NINE);
      sign     = (it.char_code == CHAR_PLUS) || (it.char_code == CHAR_MINUS);
      exp_mark = (it.char_code == CHAR_LOW_E) || (it.char_code == CHAR_UP_E);
      dot      = (it.char_code == CHAR_DOT);
      verdict  = 1'b0;
      if (!it.empty_value) begin
         // count saturates one past the limit
         if (value_length <= VALUE_LIMIT)
            value_length++;
         case (number_phase)
            PH_START: begin
               if (sign) number_phase = PH_INT;
               else if (digit) begin
                  digit_seen = 1'b1;
                  number_phase = PH_INT;
               end else if (dot) number_phase = PH_FRAC;
               else number_phase = PH_REJECT;
            end
            PH_INT: begin
               if (digit) digit_seen = 1'b1;
               else if (dot) number_phase = PH_FRAC;
               else if (exp_mark) number_phase = PH_EXP;
               else number_phase = PH_REJECT;
            end
            PH_FRAC: begin
               if (digit) digit_seen = 1'b1;
               else if (exp_mark) number_phase = PH_EXP;
               else number_phase = PH_REJECT;
            end
            PH_EXP: begin
               if (digit) number_phase = PH_EXP_NUM;
               else if (sign) number_phase = PH_EXP_SIGN;
               else number_phase = PH_REJECT;
            end
            PH_EXP_SIGN, PH_EXP_NUM: begin
               number_phase = digit ? PH_EXP_NUM : PH_REJECT;
            end
            default: number_phase = PH_REJECT;
         endcase
      end
      if (!it.last_char)
         return 1'b0;
      if (kind_reg == KIND_STRING)
         verdict = (value_length <= VALUE_LIMIT) && (value_length <= int'(length_limit));
      else
         verdict = digit_seen && (number_phase == PH_INT || number_phase == PH_FRAC ||
                                  number_phase == PH_EXP_NUM);
      number_phase = PH_START;
      digit_seen   = 1'b0;
      value_length = 0;
      return 1'b1;
   endfunction

   // driver: new values at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_char = pending_chars.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.char_code   <= next_char.char_code;
               req_bus.last_char   <= next_char.last_char;
               req_bus.empty_value <= next_char.empty_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // monitor: handshakes sampled at the rising edge
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_taken = 1'b1;
            chars_sent++;
            seen_char = '{char_code: req_bus.char_code, last_char: req_bus.last_char,
                          empty_value: req_bus.empty_value};
            has_verdict = predict_verdict(seen_char, predicted);
            if (has_verdict)
               expected_verdicts.push_back(predicted);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            verdicts_seen++;
            verdicts_accepted += int'(rsp_bus.accepted);
            if (expected_verdicts.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected verdict transaction: accepted=%0b",
                           $realtime, rsp_bus.accepted);
            end else begin
               predicted = expected_verdicts.pop_front();
               if (rsp_bus.accepted !== predicted) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("[%0t] verdict mismatch: expected accepted=%0b, got %0b",
                              $realtime, predicted, rsp_bus.accepted);
               end
            end
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || csr_wr_en)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_item(input logic [7:0] code, input logic last, input logic empty);
      pending_chars.push_back('{char_code: code, last_char: last, empty_value: empty});
   endtask

   // queue one value; noisy adds ignored empty items and sometimes ends on an empty item
   task automatic emit_value(input byte_queue_type text, input bit noisy, output int counted);
      bit end_empty;
      end_empty = noisy && ($urandom_range(9) == 0);
      counted = 0;
      if (text.size() == 0) begin
         push_item(8'($urandom_range(255)), 1'b1, 1'b1);
         counted = 1;
         return;
      end
      foreach (text[i]) begin
         if (noisy && $urandom_range(19) == 0)
            push_item(8'($urandom_range(255)), 1'b0, 1'b1);
         push_item(text[i], (i == text.size() - 1) && !end_empty, 1'b0);
         counted++;
      end
      if (end_empty) begin
         push_item(8'($urandom_range(255)), 1'b1, 1'b1);
         counted++;
      end
   endtask

   task automatic push_text(input string s);
      byte_queue_type text;
      int counted;
      for (int i = 0; i < s.len(); i++)
         text.push_back(s[i]);
      emit_value(text, 1'b0, counted);
   endtask

   task automatic add_random_value(output int counted);
      byte_queue_type text;
      int mode;
      int n;
      mode = $urandom_range(99);
      if (mode < 10) begin
         // empty value
      end else if (mode < 30) begin
         n = $urandom_range(14, 1);
         repeat (n) text.push_back(8'($urandom_range(255)));
      end else begin
         if ($urandom_range(3) == 0)
            text.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
         repeat ($urandom_range(4)) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
         if ($urandom_range(1)) begin
            text.push_back(CHAR_DOT);
            repeat ($urandom_range(3)) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
         end
         if ($urandom_range(2) == 0) begin
            text.push_back($urandom_range(1) ? CHAR_LOW_E : CHAR_UP_E);
            if ($urandom_range(1))
               text.push_back($urandom_range(1) ? CHAR_PLUS : CHAR_MINUS);
            repeat ($urandom_range(3)) text.push_back(8'(CHAR_ZERO + $urandom_range(9)));
         end
         // corrupt one character of some well-formed values
         if (mode >= 85 && text.size() != 0)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end
      emit_value(text, 1'b1, counted);
   endtask

   // block is idle: nothing queued, nothing in flight, nothing expected
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_bus.valid || expected_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] kind_data, input logic [15:0] limit_data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_COLUMN_KIND;
      csr_wr_data <= kind_data;
      kind_reg = kind_data[0];
      @(negedge clock);
      csr_index   <= CSR_MAX_LENGTH;
      csr_wr_data <= limit_data;
      length_limit = limit_data;
      @(negedge clock);
      csr_index   <= $urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B;
      csr_wr_data <= 16'($urandom_range(16'hFFFF));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int added;
      int n;
      int pick;
      logic [15:0] limit_data;

      req_bus.valid       = 1'b0;
      req_bus.char_code   = '0;
      req_bus.last_char   = 1'b0;
      req_bus.empty_value = 1'b0;
      rsp_bus.ready       = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: string column, limit zero
      push_item(8'hA5, 1'b1, 1'b1);
      push_item(8'h00, 1'b1, 1'b0);
      wait_idle();

      // extra bits of the kind write must be dropped
      set_config(16'hFFFE, 16'hFFFF);
      push_item(8'hFF, 1'b0, 1'b0);
      push_item(8'h7E, 1'b0, 1'b1);
      push_item(8'h41, 1'b1, 1'b0);
      wait_idle();

      set_config(16'h8001, 16'h0000);
      push_text("-12.5e+3");
      push_text(".5");
      push_text("1e+");
      push_text("");
      push_text(".");
      push_text("5.");
      push_text("+E7");
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
            default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
         endcase
         for (int step = 0; step < 2; step++) begin
            pick = $urandom_range(3);
            case (pick)
               0: limit_data = 16'h0000;
               1: limit_data = 16'hFFFF;
               2: limit_data = 16'($urandom_range(12));
               default: limit_data = 16'($urandom_range(16'hFFFF));
            endcase
            set_config((16'($urandom_range(16'hFFFF)) & 16'hFFFE) | 16'(step), limit_data);
            added = 0;
            while (added < ITEMS_PER_STEP) begin
               add_random_value(n);
               added += n;
            end
            wait_idle();
         end
      end

      if (expected_verdicts.size() != 0) begin
         mismatch_count += expected_verdicts.size();
         $display("%0d expected verdicts never arrived", expected_verdicts.size());
      end
      $display("Sent %0d character transactions; checked %0d verdicts (%0d accepted) in",
               chars_sent, verdicts_seen, verdicts_accepted);
      $display("both column kinds under four traffic patterns; %0d mismatches", mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
